@@ rtl/keyframe_mode_decider_core_macros.svh @@
// Assertion macros for the keyframe mode decider.
// Expects clk and arst_n in the scope of the including module.
`ifndef KEYFRAME_MODE_DECIDER_CORE_MACROS_SVH
`define KEYFRAME_MODE_DECIDER_CORE_MACROS_SVH

// implication checked at every clock edge outside reset
`define KMD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// plain invariant
`define KMD_ASSERT_ALWAYS(label, cond, msg) \
	`KMD_ASSERT_IMP(label, 1'b1, cond, msg)

`endif

@@ rtl/kmd_pkg.sv @@
// Shared types and constants for the keyframe mode decider.
// No dependencies; used by every other file of the block but the macro header.
`default_nettype none

package kmd_pkg;

	// field widths
	localparam int unsigned STAT_W   = 16;
	localparam int unsigned FRAME_W  = 32;
	localparam int unsigned BYTES_W  = 20;
	localparam int unsigned BPP_W    = 21;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned RATE_W   = BPP_W + 1;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 21;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GOP_LENGTH     = 3'd0,
		CFG_P95_LIMIT      = 3'd1,
		CFG_P99_LIMIT      = 3'd2,
		CFG_ENTROPY_LIMIT  = 3'd3,
		CFG_HYSTERESIS_BPP = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		OP_DECIDE = 1'b0,
		OP_UPDATE = 1'b1
	} opcode_t;

	typedef logic [BPP_W-1:0] bpp_t;

	localparam bpp_t BPP_MAX = '1;

	// reset values of the configuration registers
	localparam logic [STAT_W-1:0] GOP_LENGTH_RST     = 16'd60;
	localparam logic [STAT_W-1:0] P95_LIMIT_RST      = 16'd480;
	localparam logic [STAT_W-1:0] P99_LIMIT_RST      = 16'd1600;
	localparam logic [STAT_W-1:0] ENTROPY_LIMIT_RST  = 16'd24576;
	localparam bpp_t              HYSTERESIS_BPP_RST = 21'd9830;

	// bits per pixel: round(bytes * 2^19 / FRAME_PIXELS), via an exact reciprocal
	localparam int unsigned FRAME_PIXELS = 327680;
	localparam int unsigned BYTE_SHIFT   = 19;              // 8 bits, 16 fraction bits
	localparam int unsigned NUM_W        = BYTES_W + BYTE_SHIFT + 1;
	localparam int unsigned RECIP_SHIFT  = NUM_W + $clog2(FRAME_PIXELS);
	localparam int unsigned RECIP_W      = NUM_W + 1;
	localparam int unsigned RECIP_LO_W   = 20;
	localparam int unsigned RECIP_HI_W   = RECIP_W - RECIP_LO_W;
	localparam int unsigned PROD_LO_W    = BYTES_W + RECIP_LO_W;
	localparam int unsigned PROD_HI_W    = BYTES_W + RECIP_HI_W;
	localparam int unsigned PROD_W       = BYTES_W + RECIP_W;
	localparam int unsigned WIDE_W       = 96;
	localparam int unsigned QUOT_W       = WIDE_W - RECIP_SHIFT;

	localparam logic [WIDE_W-1:0] RECIP_FULL =
		((WIDE_W'(1) << RECIP_SHIFT) + WIDE_W'(FRAME_PIXELS) - WIDE_W'(1)) /
		WIDE_W'(FRAME_PIXELS);
	localparam logic [RECIP_W-1:0]    RECIP_M    = RECIP_FULL[RECIP_W-1:0];
	localparam logic [RECIP_LO_W-1:0] RECIP_LO   = RECIP_M[RECIP_LO_W-1:0];
	localparam logic [RECIP_HI_W-1:0] RECIP_HI   = RECIP_M[RECIP_W-1:RECIP_LO_W];
	localparam logic [WIDE_W-1:0]     ROUND_TERM =
		WIDE_W'(FRAME_PIXELS / 2) * RECIP_FULL;

	// moving average, alpha in Q16
	localparam int unsigned BLEND_W     = 38;
	localparam int unsigned BLEND_SHIFT = 16;
	localparam logic [BLEND_W-1:0] ALPHA_Q16 = 38'd6554;
	localparam logic [BLEND_W-1:0] KEEP_Q16  = 38'd58982;
	localparam logic [BLEND_W-1:0] HALF_Q16  = 38'd32768;

	typedef struct packed {
		logic [STAT_W-1:0] gop_length;
		logic [STAT_W-1:0] p95_limit;
		logic [STAT_W-1:0] p99_limit;
		logic [STAT_W-1:0] entropy_limit;
		bpp_t              hysteresis_bpp;
	} cfg_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [STAT_W-1:0]  stat_p95;
		logic [STAT_W-1:0]  stat_p99;
		logic [STAT_W-1:0]  stat_entropy;
		logic [FRAME_W-1:0] frame_number;
		logic [BYTES_W-1:0] coded_bytes;
		logic               coded_as_key;
	} item_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [STAT_W-1:0]  stat_p95;
		logic [STAT_W-1:0]  stat_p99;
		logic [STAT_W-1:0]  stat_entropy;
		logic [FRAME_W-1:0] frame_number;
		logic               coded_as_key;
		bpp_t               bpp;
	} work_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frames_since_key;
		logic               last_was_intra;
		logic               averages_started;
		bpp_t               residual_rate_avg;
		bpp_t               key_rate_avg;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/kmd_if.sv @@
// Valid/ready channel interfaces of the keyframe mode decider.
// Field widths come from kmd_pkg.
`default_nettype none

interface kmd_stats_if import kmd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [STAT_W-1:0]   stat_p95;
	logic [STAT_W-1:0]   stat_p99;
	logic [STAT_W-1:0]   stat_entropy;
	logic [FRAME_W-1:0]  frame_number;
	logic [BYTES_W-1:0]  coded_bytes;
	logic                coded_as_key;

	modport source (
		output valid, opcode, stat_p95, stat_p99, stat_entropy, frame_number,
			coded_bytes, coded_as_key,
		input  ready
	);
	modport sink (
		input  valid, opcode, stat_p95, stat_p99, stat_entropy, frame_number,
			coded_bytes, coded_as_key,
		output ready
	);
endinterface

interface kmd_decision_if import kmd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               intra_mode;
	logic [FRAME_W-1:0] keyframe_number;

	modport source (output valid, intra_mode, keyframe_number, input ready);
	modport sink (input valid, intra_mode, keyframe_number, output ready);
endinterface

`default_nettype wire

@@ rtl/kmd_cfg.sv @@
// Configuration register file of the keyframe mode decider.
// Depends on kmd_pkg for the register indexes and reset values.
`default_nettype none

module kmd_cfg import kmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] index,
	input  logic [CFG_DATA_W-1:0]  data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gop_length     <= GOP_LENGTH_RST;
			cfg_q.p95_limit      <= P95_LIMIT_RST;
			cfg_q.p99_limit      <= P99_LIMIT_RST;
			cfg_q.entropy_limit  <= ENTROPY_LIMIT_RST;
			cfg_q.hysteresis_bpp <= HYSTERESIS_BPP_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(index))
				CFG_GOP_LENGTH:     cfg_q.gop_length     <= data[STAT_W-1:0];
				CFG_P95_LIMIT:      cfg_q.p95_limit      <= data[STAT_W-1:0];
				CFG_P99_LIMIT:      cfg_q.p99_limit      <= data[STAT_W-1:0];
				CFG_ENTROPY_LIMIT:  cfg_q.entropy_limit  <= data[STAT_W-1:0];
				CFG_HYSTERESIS_BPP: cfg_q.hysteresis_bpp <= data[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/kmd_bpp.sv @@
// Three-stage front pipeline: input register, reciprocal multiply,
// then add, shift and saturate to bits per pixel. Depends on kmd_pkg.
`default_nettype none

module kmd_bpp import kmd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  in_ready,
	output logic  out_valid,
	output work_t out_work,
	input  logic  out_ready
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	item_t                item_s1, item_s2;
	logic [PROD_LO_W-1:0] plo_s2;
	logic [PROD_HI_W-1:0] phi_s2;
	work_t                work_s3;

	logic [PROD_LO_W-1:0] plo;
	logic [PROD_HI_W-1:0] phi;
	logic [PROD_W-1:0]    prod;
	logic [WIDE_W-1:0]    num_scaled;
	logic [QUOT_W-1:0]    quot;
	bpp_t                 bpp;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// reciprocal split in two halves to keep each multiplier narrow
	assign plo = PROD_LO_W'(item_s1.coded_bytes) * PROD_LO_W'(RECIP_LO);
	assign phi = PROD_HI_W'(item_s1.coded_bytes) * PROD_HI_W'(RECIP_HI);

	assign prod       = {phi_s2, RECIP_LO_W'(0)} + PROD_W'(plo_s2);
	assign num_scaled = (WIDE_W'(prod) << BYTE_SHIFT) + ROUND_TERM;
	assign quot       = num_scaled[RECIP_SHIFT +: QUOT_W];
	assign bpp        = (quot > QUOT_W'(BPP_MAX)) ? BPP_MAX : quot[BPP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= in_item;
		end
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_s1;
			plo_s2  <= plo;
			phi_s2  <= phi;
		end
		if (rdy_s3 && v_s2) begin
			work_s3.opcode       <= item_s2.opcode;
			work_s3.stat_p95     <= item_s2.stat_p95;
			work_s3.stat_p99     <= item_s2.stat_p99;
			work_s3.stat_entropy <= item_s2.stat_entropy;
			work_s3.frame_number <= item_s2.frame_number;
			work_s3.coded_as_key <= item_s2.coded_as_key;
			work_s3.bpp          <= bpp;
		end
	end

	assign out_valid = v_s3;
	assign out_work  = work_s3;

endmodule

`default_nettype wire

@@ rtl/kmd_state.sv @@
// Decision and rate-average stage: holds the per-stream state, updates it
// once per word and registers the decision. Depends on kmd_pkg, kmd_if.
`default_nettype none

module kmd_state import kmd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  work_valid,
	input  work_t                 work,
	output logic                  work_ready,
	kmd_decision_if.source        decision,
	output status_t               status
);

	logic [COUNT_W-1:0] fsk_q;
	logic [FRAME_W-1:0] last_key_q;
	logic               last_intra_q;
	bpp_t               res_avg_q;
	bpp_t               key_avg_q;
	logic               started_q;
	logic               out_valid_q;
	logic               intra_mode_q;
	logic [FRAME_W-1:0] key_num_q;

	logic               is_update;
	logic               update_fire;
	logic               decide_fire;
	logic [COUNT_W-1:0] fsk_inc;
	logic               gop_hit;
	logic               stat_hit;
	logic [RATE_W-1:0]  rate_lhs;
	logic [RATE_W-1:0]  rate_rhs;
	logic               rate_hit;
	logic               intra;
	logic [FRAME_W-1:0] key_next;
	bpp_t               avg_sel;
	logic [BLEND_W-1:0] blend_sum;
	bpp_t               avg_new;

	assign is_update   = (work.opcode == OP_UPDATE);
	// update words never occupy the output register
	assign work_ready  = is_update || !out_valid_q || decision.ready;
	assign update_fire = work_valid && work_ready && is_update;
	assign decide_fire = work_valid && work_ready && !is_update;

	assign fsk_inc  = (fsk_q != '1) ? fsk_q + COUNT_W'(1) : fsk_q;
	assign gop_hit  = (fsk_inc >= cfg.gop_length);
	assign stat_hit = (work.stat_p95 > cfg.p95_limit) ||
		(work.stat_p99 > cfg.p99_limit) ||
		(work.stat_entropy > cfg.entropy_limit);

	// res > key -/+ hyst, moved around so both sides stay unsigned
	always_comb begin
		if (last_intra_q) begin
			rate_lhs = RATE_W'(res_avg_q) + RATE_W'(cfg.hysteresis_bpp);
			rate_rhs = RATE_W'(key_avg_q);
		end else begin
			rate_lhs = RATE_W'(res_avg_q);
			rate_rhs = RATE_W'(key_avg_q) + RATE_W'(cfg.hysteresis_bpp);
		end
	end

	assign rate_hit = started_q && (rate_lhs > rate_rhs);
	assign intra    = gop_hit || stat_hit || rate_hit;
	assign key_next = intra ? work.frame_number : last_key_q;

	assign avg_sel   = work.coded_as_key ? key_avg_q : res_avg_q;
	assign blend_sum = ALPHA_Q16 * BLEND_W'(work.bpp) + KEEP_Q16 * BLEND_W'(avg_sel) +
		HALF_Q16;
	assign avg_new   = started_q ? blend_sum[BLEND_SHIFT +: BPP_W] : work.bpp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsk_q        <= '0;
			last_key_q   <= '0;
			last_intra_q <= 1'b1;
			res_avg_q    <= '0;
			key_avg_q    <= '0;
			started_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (update_fire) begin
				started_q <= 1'b1;
				if (work.coded_as_key) key_avg_q <= avg_new;
				else                   res_avg_q <= avg_new;
			end
			if (decide_fire) begin
				fsk_q        <= intra ? '0 : fsk_inc;
				last_key_q   <= key_next;
				last_intra_q <= intra;
			end
			if (decide_fire)         out_valid_q <= 1'b1;
			else if (decision.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_fire) begin
			intra_mode_q <= intra;
			key_num_q    <= key_next;
		end
	end

	assign decision.valid           = out_valid_q;
	assign decision.intra_mode      = intra_mode_q;
	assign decision.keyframe_number = key_num_q;

	assign status.frames_since_key  = fsk_q;
	assign status.last_was_intra    = last_intra_q;
	assign status.averages_started  = started_q;
	assign status.residual_rate_avg = res_avg_q;
	assign status.key_rate_avg      = key_avg_q;

endmodule

`default_nettype wire

@@ rtl/keyframe_mode_decider_core.sv @@
// Top level of the keyframe mode decider: configuration registers,
// bits-per-pixel front pipeline and decision stage.
// Depends on kmd_pkg, kmd_if, kmd_cfg, kmd_bpp, kmd_state and the macro header.
//
//  channel    dir  handshake     payload
//  stats      in   valid/ready   opcode, stat_p95/p99/entropy, frame_number,
//                                coded_bytes, coded_as_key
//  decision   out  valid/ready   intra_mode, keyframe_number (decide words only)
//  cfg_*      in   cfg_wr_en     cfg_index, cfg_data
//
// One word per cycle sustained while no decision is held back. A decide word
// passes the input register, multiply stage and bpp stage; then the state stage
// writes the output register. The state stage updates its state on each word.
// Asynchronous active-low reset; no clearing pass, ready as soon as reset drops.
// A held decision stalls only decide words at the state stage; the front
// pipeline keeps accepting until its three stages are full.
`default_nettype none

`include "keyframe_mode_decider_core_macros.svh"

module keyframe_mode_decider_core import kmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	kmd_stats_if.sink              stats,
	kmd_decision_if.source         decision,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t    cfg;
	item_t   item;
	logic    work_valid;
	logic    work_ready;
	work_t   work;
	status_t status;

	assign item.opcode       = opcode_t'(stats.opcode);
	assign item.stat_p95     = stats.stat_p95;
	assign item.stat_p99     = stats.stat_p99;
	assign item.stat_entropy = stats.stat_entropy;
	assign item.frame_number = stats.frame_number;
	assign item.coded_bytes  = stats.coded_bytes;
	assign item.coded_as_key = stats.coded_as_key;

	kmd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	kmd_bpp u_bpp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stats.valid),
		.in_item   (item),
		.in_ready  (stats.ready),
		.out_valid (work_valid),
		.out_work  (work),
		.out_ready (work_ready)
	);

	kmd_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.work_valid (work_valid),
		.work       (work),
		.work_ready (work_ready),
		.decision   (decision),
		.status     (status)
	);

	// the held decision always reflects the latest decide word
	`KMD_ASSERT_IMP(a_held_mode, decision.valid, decision.intra_mode == status.last_was_intra, "stale mode")
	`KMD_ASSERT_IMP(a_intra_count, decision.valid && decision.intra_mode, status.frames_since_key == '0, "count kept")
	`KMD_ASSERT_ALWAYS(a_avgs_zero_unseeded, status.averages_started || (status.key_rate_avg == '0 && status.residual_rate_avg == '0), "average moved before seeding")

endmodule

`default_nettype wire
